### design/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg: shared constants for the serial frame decoder
// Header bytes, type key table and the type-select record.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int NUM_TYPES = 11;
  localparam int KEY_MAX   = 11;
  localparam int TYPE_W    = 4;
  localparam int POS_W     = 9;
  localparam int KIDX_W    = 4;

  localparam logic [7:0] HDR_FIRST  = 8'h55;
  localparam logic [7:0] HDR_SECOND = 8'hAA;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CHECKSUM = 2'd1;
  localparam logic [1:0] ST_UNKNOWN  = 2'd2;

  // Key length of each type, in decode order.
  localparam logic [POS_W-1:0] KEY_LEN [NUM_TYPES] = '{
    9'd3, 9'd3, 9'd8, 9'd8, 9'd8, 9'd8, 9'd8, 9'd8, 9'd8, 9'd8, 9'd11
  };

  // Key bytes, padded with zero past each key's length.
  localparam logic [7:0] KEY_TAB [NUM_TYPES][KEY_MAX] = '{
    '{8'd0, 8'd0, 8'd0, 8'd0,   8'd0,   8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd3, 8'd4, 8'd0, 8'd0,   8'd0,   8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd3, 8'd7, 8'd0, 8'd5,   8'd10,  8'd1, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0},
    '{8'd3, 8'd7, 8'd0, 8'd5,   8'd101, 8'd4, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0},
    '{8'd3, 8'd7, 8'd0, 8'd5,   8'd102, 8'd4, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0},
    '{8'd3, 8'd7, 8'd0, 8'd5,   8'd103, 8'd1, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0},
    '{8'd3, 8'd7, 8'd0, 8'd5,   8'd104, 8'd1, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0},
    '{8'd3, 8'd7, 8'd0, 8'd5,   8'd105, 8'd4, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0},
    '{8'd3, 8'd7, 8'd0, 8'd5,   8'd106, 8'd4, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0},
    '{8'd3, 8'd7, 8'd0, 8'd5,   8'd108, 8'd4, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0},
    '{8'd3, 8'd7, 8'd0, 8'd8,   8'd109, 8'd2, 8'd0, 8'd4, 8'd0, 8'd0, 8'd0}
  };

  typedef struct packed {
    logic              found;
    logic [TYPE_W-1:0] code;
  } type_sel_t;

endpackage

### design/serial_frame_decoder.sv
// ----------------------------------------------------------------------------
// serial_frame_decoder: byte-serial frame decoder
// Hunts for the 0x55 0xAA header, checks the frame sum and type key.
// ----------------------------------------------------------------------------
// One received byte per item, one item per cycle unless the input stalls. A
// byte is captured in an input register, then a single pass of logic updates
// the frame state and, on the checksum byte, loads the result register. Input
// stalls only when a result is due while the result register is still full
// and not being taken.
module serial_frame_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_ready,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  input  logic       res_ready,
  output logic [1:0] status,
  output logic [3:0] msg_type,
  output logic [7:0] msg_value
);

  localparam logic [1:0] PH_HUNT  = 2'd0;
  localparam logic [1:0] PH_SEEN  = 2'd1;
  localparam logic [1:0] PH_FRAME = 2'd2;

  localparam int NT = sfd_pkg::NUM_TYPES;
  localparam int PW = sfd_pkg::POS_W;

  logic          hold_v;
  logic [7:0]    hold_b;

  logic [1:0]    phase, phase_next;
  logic [PW-1:0] pos, pos_next;
  logic [7:0]    len, len_next;
  logic [7:0]    sum, sum_next;
  logic [7:0]    prev, prev_next;
  logic [NT-1:0] mask, mask_next;

  logic [7:0]    len_eff;
  logic [PW-1:0] key_idx;
  logic [NT-1:0] mask_narrow;
  logic          frame_end;
  logic          adv;
  logic [1:0]    st;
  sfd_pkg::type_sel_t type_sel;

  assign len_eff   = (pos == PW'(5)) ? hold_b : len;
  assign key_idx   = pos - PW'(2);
  assign frame_end = (phase == PH_FRAME) && (pos >= PW'(6))
                     && (pos == {1'b0, len_eff} + PW'(6));

  assign adv      = hold_v && (!frame_end || !res_valid || res_ready);
  assign rx_ready = !hold_v || adv;

  sfd_key_match u_key (
    .key_idx    (key_idx),
    .key_byte   (hold_b),
    .mask       (mask),
    .pay_len    (len),
    .mask_narrow(mask_narrow),
    .type_sel   (type_sel)
  );

  always_comb begin
    if (sum != hold_b) begin
      st = sfd_pkg::ST_CHECKSUM;
    end else if (!type_sel.found) begin
      st = sfd_pkg::ST_UNKNOWN;
    end else begin
      st = sfd_pkg::ST_OK;
    end
  end

  always_comb begin
    phase_next = phase;
    pos_next   = pos;
    len_next   = len;
    sum_next   = sum;
    prev_next  = prev;
    mask_next  = mask;
    case (phase)
      PH_SEEN: begin
        if (hold_b == sfd_pkg::HDR_SECOND) begin
          phase_next = PH_FRAME;
          pos_next   = PW'(2);
          len_next   = '0;
          sum_next   = sfd_pkg::HDR_FIRST + sfd_pkg::HDR_SECOND;
          prev_next  = '0;
          mask_next  = '1;
        end else if (hold_b != sfd_pkg::HDR_FIRST) begin
          phase_next = PH_HUNT;
        end
      end
      PH_FRAME: begin
        if (pos == PW'(5)) begin
          len_next = hold_b;
        end
        if (frame_end) begin
          phase_next = PH_HUNT;
          pos_next   = '0;
        end else begin
          if (pos <= {1'b0, len_eff} + PW'(4)) begin
            mask_next = mask_narrow;
          end
          sum_next  = sum + hold_b;
          prev_next = hold_b;
          pos_next  = pos + PW'(1);
        end
      end
      default: begin
        phase_next = (hold_b == sfd_pkg::HDR_FIRST) ? PH_SEEN : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v    <= 1'b0;
      phase     <= PH_HUNT;
      pos       <= '0;
      len       <= '0;
      sum       <= '0;
      prev      <= '0;
      mask      <= '1;
      res_valid <= 1'b0;
    end else begin
      if (rx_valid && rx_ready) begin
        hold_v <= 1'b1;
      end else if (adv) begin
        hold_v <= 1'b0;
      end
      if (adv) begin
        phase <= phase_next;
        pos   <= pos_next;
        len   <= len_next;
        sum   <= sum_next;
        prev  <= prev_next;
        mask  <= mask_next;
      end
      if (adv && frame_end) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rx_valid && rx_ready) begin
      hold_b <= rx_byte;
    end
    if (adv && frame_end) begin
      status    <= st;
      msg_type  <= (st == sfd_pkg::ST_OK) ? type_sel.code : '0;
      msg_value <= (st == sfd_pkg::ST_OK) ? prev : '0;
    end
  end

endmodule

### design/sfd_key_match.sv
// ----------------------------------------------------------------------------
// sfd_key_match: type key narrowing and type lookup
// Drops candidates whose key differs at or ends before the current key index;
// picks the lowest surviving candidate whose key length is payload length + 3.
// ----------------------------------------------------------------------------
module sfd_key_match (
  input  logic [sfd_pkg::POS_W-1:0]     key_idx,
  input  logic [7:0]                    key_byte,
  input  logic [sfd_pkg::NUM_TYPES-1:0] mask,
  input  logic [7:0]                    pay_len,
  output logic [sfd_pkg::NUM_TYPES-1:0] mask_narrow,
  output sfd_pkg::type_sel_t            type_sel
);

  logic [sfd_pkg::KIDX_W-1:0] kidx;
  logic [sfd_pkg::POS_W-1:0]  want_len;

  assign kidx     = key_idx[sfd_pkg::KIDX_W-1:0];
  assign want_len = {1'b0, pay_len} + sfd_pkg::POS_W'(3);

  always_comb begin
    for (int e = 0; e < sfd_pkg::NUM_TYPES; e++) begin
      if (key_idx < sfd_pkg::KEY_LEN[e] && sfd_pkg::KEY_TAB[e][kidx] == key_byte) begin
        mask_narrow[e] = mask[e];
      end else begin
        mask_narrow[e] = 1'b0;
      end
    end
  end

  // lowest index wins
  always_comb begin
    type_sel = '0;
    for (int e = sfd_pkg::NUM_TYPES - 1; e >= 0; e--) begin
      if (mask[e] && sfd_pkg::KEY_LEN[e] == want_len) begin
        type_sel.found = 1'b1;
        type_sel.code  = sfd_pkg::TYPE_W'(e);
      end
    end
  end

endmodule
